/* design/smtp_reply_parser_core_defines.svh */
// Assertion helpers used by the checker file
`ifndef SMTP_REPLY_PARSER_CORE_DEFINES_SVH
`define SMTP_REPLY_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is held
`define SRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srp check failed");

// Next-cycle implication, masked while reset is held
`define SRP_ASSERT_NEXT(lbl, clk, ante, cons, rst_n) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srp check failed");

// Next-cycle implication that also holds across reset
`define SRP_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("srp check failed");

`endif

/* design/srp_pkg.sv */
`default_nettype none

package srp_pkg;

    localparam int CODE_W           = 10;
    localparam int LINE_LIMIT_DEF   = 512;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_CHANGED   = 2'd2,
        ST_TOO_LONG  = 2'd3
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        status_t           status;
    } result_t;

endpackage

`default_nettype wire

/* design/smtp_reply_parser_core.sv */
// SMTP reply code parser. Takes the server's reply stream one byte per transfer and
// gives one result per finished reply (status 0 with the three digit code) or per
// error (malformed line, code changed within a multi-line reply, or a line of
// LINE_LIMIT bytes without LF; reply_code is then zero). Continuation lines and
// ordinary bytes give no result. The block takes one byte every cycle while the
// result register is not blocked; a byte passes through an input register and the
// per-byte checks into the result register, from which its result is offered. Input
// is held off only while an undelivered result blocks the result register.

`default_nettype none

module smtp_reply_parser_core
    import srp_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_rx_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CODE_W-1:0]      m_reply_code,
    output logic [1:0]             m_status
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    status_t           out_status_reg;
    logic              advance;
    result_t           res;

    // Move the held byte on whenever the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    srp_line_parser #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    // Input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && res.valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_code_reg   <= res.code;
            out_status_reg <= res.status;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_reply_code = out_code_reg;
    assign m_status     = out_status_reg;

endmodule

`default_nettype wire

/* design/srp_line_parser.sv */
`default_nettype none

module srp_line_parser
    import srp_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic [7:0] rx_byte,
    output result_t         res
);

    localparam int PosW = $clog2(LINE_LIMIT + 1);
    localparam logic [PosW-1:0] PosLast = PosW'(LINE_LIMIT - 1);
    localparam logic [PosW-1:0] PosSep  = PosW'(3);

    logic [PosW-1:0]   pos_reg,     pos_next;
    logic [CODE_W-1:0] code_reg,    code_next;
    logic              bad_reg,     bad_next;
    logic              dash_reg,    dash_next;
    logic [CODE_W-1:0] held_reg,    held_next;
    logic              open_reg,    open_next;
    logic              discard_reg, discard_next;

    logic              is_lf;
    logic              is_digit;
    logic [3:0]        digit;
    logic              line_bad;

    assign is_lf    = (rx_byte == CHAR_LF);
    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign digit    = 4'(rx_byte - CHAR_ZERO);
    assign line_bad = bad_reg || (pos_reg < PosSep);

    // Work out the next line and reply state and any result for this byte
    always_comb begin
        pos_next     = pos_reg;
        code_next    = code_reg;
        bad_next     = bad_reg;
        dash_next    = dash_reg;
        held_next    = held_reg;
        open_next    = open_reg;
        discard_next = discard_reg;
        res          = '{valid: 1'b0, code: '0, status: ST_DONE};

        if (discard_reg) begin
            // drop the rest of an overlong line
            if (is_lf) begin
                discard_next = 1'b0;
                pos_next     = '0;
                code_next    = '0;
                bad_next     = 1'b0;
                dash_next    = 1'b0;
            end
        end else if (is_lf) begin
            // close the line and judge it
            pos_next  = '0;
            code_next = '0;
            bad_next  = 1'b0;
            dash_next = 1'b0;
            if (line_bad) begin
                held_next = '0;
                open_next = 1'b0;
                res       = '{valid: 1'b1, code: '0, status: ST_MALFORMED};
            end else if (open_reg && (code_reg != held_reg)) begin
                held_next = '0;
                open_next = 1'b0;
                res       = '{valid: 1'b1, code: '0, status: ST_CHANGED};
            end else if (dash_reg) begin
                open_next = 1'b1;
                held_next = code_reg;
            end else begin
                held_next = '0;
                open_next = 1'b0;
                res       = '{valid: 1'b1, code: code_reg, status: ST_DONE};
            end
        end else begin
            // check the code digits and the separator
            if (pos_reg < PosSep) begin
                if (!is_digit || ((pos_reg == '0) && (rx_byte == CHAR_ZERO))) begin
                    bad_next = 1'b1;
                end else begin
                    code_next = CODE_W'({code_reg, 3'b000}) + CODE_W'({code_reg, 1'b0})
                              + CODE_W'(digit);
                end
            end else if (pos_reg == PosSep) begin
                dash_next = (rx_byte == CHAR_DASH);
                if (rx_byte != CHAR_SPACE && rx_byte != CHAR_DASH &&
                    rx_byte != CHAR_CR && rx_byte != CHAR_NUL) begin
                    bad_next = 1'b1;
                end
            end

            // advance the position, or abandon a line that has grown too long
            if (pos_reg == PosLast) begin
                pos_next     = '0;
                code_next    = '0;
                bad_next     = 1'b0;
                dash_next    = 1'b0;
                held_next    = '0;
                open_next    = 1'b0;
                discard_next = 1'b1;
                res          = '{valid: 1'b1, code: '0, status: ST_TOO_LONG};
            end else begin
                pos_next = pos_reg + PosW'(1);
            end
        end
    end

    // Hold line and reply state between bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            code_reg    <= '0;
            bad_reg     <= 1'b0;
            dash_reg    <= 1'b0;
            held_reg    <= '0;
            open_reg    <= 1'b0;
            discard_reg <= 1'b0;
        end else if (step_en) begin
            pos_reg     <= pos_next;
            code_reg    <= code_next;
            bad_reg     <= bad_next;
            dash_reg    <= dash_next;
            held_reg    <= held_next;
            open_reg    <= open_next;
            discard_reg <= discard_next;
        end
    end

endmodule

`default_nettype wire

/* design/srp_checker.sv */
`default_nettype none

`include "smtp_reply_parser_core_defines.svh"

module srp_checker
    import srp_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic [7:0]        s_rx_byte,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [CODE_W-1:0] m_reply_code,
    input wire logic [1:0]        m_status
);

    logic in_stall;
    logic out_stall;
    logic err_out;
    logic done_out;
    logic code_in_range;

    assign in_stall      = s_valid && !s_ready;
    assign out_stall     = m_valid && !m_ready;
    assign err_out       = m_valid && (m_status != ST_DONE);
    assign done_out      = m_valid && (m_status == ST_DONE);
    assign code_in_range = (m_reply_code >= CODE_W'(100)) && (m_reply_code <= CODE_W'(999));

    // an error result never carries a code
    `SRP_ASSERT_NOW(a_err_code_zero, aclk, aresetn, err_out, m_reply_code == '0)

    // a finished reply carries a three digit code with a non-zero first digit
    `SRP_ASSERT_NOW(a_done_code_range, aclk, aresetn, done_out, code_in_range)

    // a waiting input byte holds
    `SRP_ASSERT_NEXT(a_in_hold, aclk, in_stall, s_valid && $stable(s_rx_byte), aresetn)

    // a stalled result holds
    `SRP_ASSERT_NEXT(a_out_hold, aclk, out_stall, m_valid && $stable({m_reply_code, m_status}), aresetn)

    // nothing is offered straight out of reset
    `SRP_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_valid)

endmodule

bind smtp_reply_parser_core srp_checker u_srp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_rx_byte    (s_rx_byte),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_reply_code (m_reply_code),
    .m_status     (m_status)
);

`default_nettype wire
